[sv/ttms_pkg.sv]
// Shared types, codes and reset values for the tape transport mode sequencer.
// No dependencies; imported by ttms_step and tape_transport_mode_sequencer.
package ttms_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int CFG_WIDTH        = 16;
  localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH
                                                                   : CFG_WIDTH;

  typedef enum logic [3:0] {
    MODE_STOPPED   = 4'd0,
    MODE_PLAY      = 4'd1,
    MODE_FF        = 4'd2,
    MODE_REW       = 4'd3,
    MODE_FF_DOWN   = 4'd4,
    MODE_REW_DOWN  = 4'd5,
    MODE_PLAY_DOWN = 4'd6,
    MODE_IDLE      = 4'd7,
    MODE_GOTO      = 4'd8
  } mode_t;

  typedef logic [2:0] action_t;
  localparam action_t ACT_NONE = 3'd0;
  localparam action_t ACT_PLAY = 3'd1;
  localparam action_t ACT_STOP = 3'd2;
  localparam action_t ACT_FF   = 3'd3;
  localparam action_t ACT_REW  = 3'd4;
  localparam action_t ACT_MEM  = 3'd5;

  typedef logic [1:0] pinch_t;
  localparam pinch_t PINCH_KEEP    = 2'd0;
  localparam pinch_t PINCH_ENGAGE  = 2'd1;
  localparam pinch_t PINCH_RELEASE = 2'd2;

  localparam logic       FUNC_TICK   = 1'b0;
  localparam logic       FUNC_ACTION = 1'b1;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_PINCH_DELAY    = 2'd0;
  localparam cfg_index_t CFG_WIND_DOWN      = 2'd1;
  localparam cfg_index_t CFG_PLAY_WIND_DOWN = 2'd2;
  localparam cfg_index_t CFG_SPEED_THRESH   = 2'd3;

  localparam logic [15:0] PINCH_DELAY_RESET    = 16'd500;
  localparam logic [15:0] WIND_DOWN_RESET      = 16'd1000;
  localparam logic [15:0] PLAY_WIND_DOWN_RESET = 16'd500;
  localparam logic [14:0] SPEED_THRESH_RESET   = 15'd128;   // 0.5 in Q7.8

  typedef struct packed {
    logic [15:0] pinch_delay_ticks;
    logic [15:0] wind_down_ticks;
    logic [15:0] playback_wind_down_ticks;
    logic [14:0] speed_threshold;
  } cfg_t;

  typedef struct packed {
    mode_t                       mode;
    action_t                     pending;
    logic [TICK_COUNT_WIDTH-1:0] count;
  } state_t;

  typedef struct packed {
    mode_t  mode;
    logic   reel_drives_enabled;
    logic   capstan_enabled;
    pinch_t pinch_command;
    logic   idle_ready;
  } result_t;

endpackage

[sv/ttms_step.sv]
// Combinational next-state and result logic for one sequencer beat.
// Depends on ttms_pkg for the mode, action, config and state types.
module ttms_step
  import ttms_pkg::*;
(
  input  state_t             cur,
  input  cfg_t               cfg,
  input  logic               func,
  input  logic [2:0]         action_code,
  input  logic signed [15:0] supply_reel_speed,
  input  logic signed [15:0] takeup_reel_speed,
  output state_t             nxt,
  output result_t            res
);

  typedef struct packed {
    mode_t   mode;
    action_t pending;
    logic    entered;
    pinch_t  pinch;
  } act_res_t;

  // Mode transition table for one action.
  function automatic act_res_t apply_action(mode_t m, action_t p, action_t a);
    act_res_t r;
    r.mode    = m;
    r.pending = p;
    r.entered = 1'b0;
    r.pinch   = PINCH_KEEP;
    if (a != ACT_NONE && a <= ACT_MEM) begin
      case (m)
        MODE_STOPPED, MODE_IDLE: begin
          r.entered = 1'b1;
          r.pinch   = PINCH_RELEASE;
          case (a)
            ACT_PLAY: begin
              r.mode  = MODE_PLAY;
              r.pinch = PINCH_KEEP;
            end
            ACT_STOP: r.mode = MODE_STOPPED;
            ACT_FF:   r.mode = MODE_FF;
            ACT_REW:  r.mode = MODE_REW;
            default:  r.mode = MODE_GOTO;
          endcase
        end
        MODE_FF: begin
          if (a != ACT_FF) begin
            r.mode    = MODE_FF_DOWN;
            r.pending = a;
            r.entered = 1'b1;
          end
        end
        MODE_REW: begin
          if (a != ACT_REW) begin
            r.mode    = MODE_REW_DOWN;
            r.pending = a;
            r.entered = 1'b1;
          end
        end
        MODE_PLAY: begin
          if (a != ACT_PLAY) begin
            r.mode    = MODE_PLAY_DOWN;
            r.pending = a;
            r.entered = 1'b1;
            r.pinch   = PINCH_RELEASE;
          end
        end
        MODE_FF_DOWN, MODE_REW_DOWN, MODE_PLAY_DOWN: r.pending = a;
        default: ;
      endcase
    end
    return r;
  endfunction

  localparam logic [TICK_COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [CMP_WIDTH-1:0]  count_ext;
  logic [CMP_WIDTH-1:0]  pinch_delay_ext;
  logic [CMP_WIDTH-1:0]  wind_down_ext;
  logic [CMP_WIDTH-1:0]  play_down_ext;
  logic signed [16:0]    th_pos;
  logic signed [16:0]    th_neg;
  logic signed [16:0]    s_ext;
  logic signed [16:0]    t_ext;
  logic                  speeds_ok;
  act_res_t              act_r;
  act_res_t              idle_r;
  logic [TICK_COUNT_WIDTH-1:0] count_base;

  assign count_ext       = CMP_WIDTH'(cur.count);
  assign pinch_delay_ext = CMP_WIDTH'(cfg.pinch_delay_ticks);
  assign wind_down_ext   = CMP_WIDTH'(cfg.wind_down_ticks);
  assign play_down_ext   = CMP_WIDTH'(cfg.playback_wind_down_ticks);

  assign th_pos = signed'({2'b00, cfg.speed_threshold});
  assign th_neg = -th_pos;
  assign s_ext  = 17'(supply_reel_speed);
  assign t_ext  = 17'(takeup_reel_speed);
  assign speeds_ok = (s_ext < th_pos) && (s_ext > th_neg) &&
                     (t_ext < th_pos) && (t_ext > th_neg);

  assign act_r  = apply_action(cur.mode, cur.pending, action_code);
  assign idle_r = apply_action(cur.mode, cur.pending, cur.pending);

  always_comb begin
    nxt            = cur;
    res.pinch_command = PINCH_KEEP;
    res.idle_ready = 1'b0;
    count_base     = cur.count;
    if (func == FUNC_TICK) begin
      case (cur.mode)
        MODE_PLAY: begin
          if (count_ext == pinch_delay_ext) res.pinch_command = PINCH_ENGAGE;
        end
        MODE_FF_DOWN, MODE_REW_DOWN: begin
          if (count_ext >= wind_down_ext) begin
            nxt.mode   = MODE_IDLE;
            count_base = '0;
          end
        end
        MODE_PLAY_DOWN: begin
          if (count_ext >= play_down_ext) begin
            nxt.mode   = MODE_IDLE;
            count_base = '0;
          end
        end
        MODE_IDLE: begin
          if (speeds_ok) begin
            res.idle_ready    = 1'b1;
            res.pinch_command = idle_r.pinch;
            nxt.mode          = idle_r.mode;
            nxt.pending       = ACT_NONE;
            if (idle_r.entered) count_base = '0;
          end
        end
        default: ;
      endcase
      // Saturating tick count, applied after any mode change cleared it.
      nxt.count = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
    end else begin
      res.pinch_command = act_r.pinch;
      nxt.mode          = act_r.mode;
      nxt.pending       = act_r.pending;
      if (act_r.entered) nxt.count = '0;
    end
    res.mode                = nxt.mode;
    res.reel_drives_enabled = (nxt.mode != MODE_STOPPED);
    res.capstan_enabled     = (nxt.mode == MODE_PLAY);
  end

endmodule

[sv/tape_transport_mode_sequencer.sv]
// Tape transport mode sequencer: one result beat for every item beat.
// Each result is registered in the output register, or in the skid entry while that is held.
// Items: one per cycle unless item_stall is high; each mode/count update feeds the next item.
// A two-entry result buffer (output register plus skid) keeps items flowing while a result
// waits; the item side stalls only when both entries hold results.
// Synchronous active-high reset clears state to stopped, no pending action, count zero,
// and loads the register defaults.
module tape_transport_mode_sequencer
  import ttms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Item channel.
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               func,
  input  logic [2:0]         action_code,
  input  logic signed [15:0] supply_reel_speed,
  input  logic signed [15:0] takeup_reel_speed,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         mode,
  output logic               reel_drives_enabled,
  output logic               capstan_enabled,
  output logic [1:0]         pinch_command,
  output logic               idle_ready
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  logic    item_take;
  logic    result_take;

  // Configuration registers. Writes must arrive only while the block is idle; it does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pinch_delay_ticks        <= PINCH_DELAY_RESET;
      cfg.wind_down_ticks          <= WIND_DOWN_RESET;
      cfg.playback_wind_down_ticks <= PLAY_WIND_DOWN_RESET;
      cfg.speed_threshold          <= SPEED_THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PINCH_DELAY:    cfg.pinch_delay_ticks        <= cfg_data;
        CFG_WIND_DOWN:      cfg.wind_down_ticks          <= cfg_data;
        CFG_PLAY_WIND_DOWN: cfg.playback_wind_down_ticks <= cfg_data;
        CFG_SPEED_THRESH:   cfg.speed_threshold          <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // The whole transition is worked out in one pass from the current state
  // and the item on the ports.
  ttms_step u_step (
    .cur               (state),
    .cfg               (cfg),
    .func              (func),
    .action_code       (action_code),
    .supply_reel_speed (supply_reel_speed),
    .takeup_reel_speed (takeup_reel_speed),
    .nxt               (state_next),
    .res               (step_res)
  );

  // The item side stalls only once the skid entry is taken, so it never
  // waits on the downstream stall combinationally.
  assign item_stall  = skid_valid;
  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode    <= MODE_STOPPED;
      state.pending <= ACT_NONE;
      state.count   <= '0;
    end else if (item_take) begin
      state <= state_next;
    end
  end

  // Result buffer. When the output register is busy and not being drained,
  // the new result parks in the skid entry; the skid drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (item_take) begin
      if (!result_valid || result_take) begin
        out_reg      <= step_res;
        result_valid <= 1'b1;
      end else begin
        skid_reg   <= step_res;
        skid_valid <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  assign mode                = out_reg.mode;
  assign reel_drives_enabled = out_reg.reel_drives_enabled;
  assign capstan_enabled     = out_reg.capstan_enabled;
  assign pinch_command       = out_reg.pinch_command;
  assign idle_ready          = out_reg.idle_ready;

endmodule
